>>> sv/image_datagram_segmenter_macros.svh
// assertion macros for the image datagram segmenter
// used by modules that carry concurrent checks; needs clk and rst_n in scope
`ifndef IMAGE_DATAGRAM_SEGMENTER_MACROS_SVH
`define IMAGE_DATAGRAM_SEGMENTER_MACROS_SVH

`ifndef SYNTH
// condition holds at every edge out of reset
`define IDS_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// antecedent implies consequent in the next cycle
`define IDS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define IDS_ASSERT(lbl, cond, msg)
`define IDS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> sv/ids_pkg.sv
// shared types and constants of the image datagram segmenter
// no dependencies
package ids_pkg;

    localparam int unsigned ADDR_W = 6;
    localparam int unsigned DATA_W = 64;

    localparam logic [4:0]  HDR_BYTES    = 5'd21;
    localparam logic [15:0] HDR_BYTES_16 = 16'd21;
    localparam logic [15:0] MIN_DGRAM    = 16'd22;
    localparam logic [15:0] NONFINAL_LEN = 16'd1003;
    localparam logic [15:0] RESET_DGRAM  = 16'd1024;
    localparam logic [31:0] RESET_ILEN   = 32'd1;

    // register indexes, byte address is 8 times the index
    localparam logic [2:0] REG_DGRAM_SIZE = 3'd0;
    localparam logic [2:0] REG_IMAGE_LEN  = 3'd1;
    localparam logic [2:0] REG_MSG_IDS    = 3'd2;
    localparam logic [2:0] REG_TIME_STAMP = 3'd3;
    localparam logic [2:0] REG_IMAGE_DIMS = 3'd4;
    localparam logic [2:0] REG_IMAGE_FMT  = 3'd5;

    typedef struct packed {
        logic [15:0] datagram_size;
        logic [31:0] image_length;
        logic [31:0] message_ids;
        logic [31:0] time_stamp;
        logic [47:0] image_dims;
        logic [39:0] image_format;
    } cfg_t;

    // one classified word between front and back
    typedef struct packed {
        logic [7:0]  pixel_byte;
        logic        start;
        logic [15:0] length_word;
        logic        datagram_last;
        logic        image_last;
    } qent_t;

endpackage

>>> sv/ids_pix_if.sv
// input channel: one image byte per word
// no dependencies
interface ids_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_byte;

    modport source (output valid, output pixel_byte, input ready);
    modport sink (input valid, input pixel_byte, output ready);
endinterface

>>> sv/ids_dgram_if.sv
// output channel: one datagram byte per word with framing flags
// no dependencies
interface ids_dgram_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       datagram_last;
    logic       image_last;

    modport source (output valid, output out_byte, output run_last,
                    output datagram_last, output image_last, input ready);
    modport sink (input valid, input out_byte, input run_last,
                  input datagram_last, input image_last, output ready);
endinterface

>>> sv/image_datagram_segmenter.sv
// image datagram segmenter: one word per cycle out while the receiver is ready, a 21-byte header
// ahead of each datagram; a payload word passes through the queue and the output register, and a
// word that opens a datagram follows its 21 header words
// input runs at one word per cycle while the front queue has room and stalls while the back end
// emits a header once the queue fills
// reset is asynchronous active low: counters, queue and output valid clear, registers take
// their reset values; no clearing pass
module image_datagram_segmenter #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ids_pkg::ADDR_W-1:0]  paddr,
    input  logic [ids_pkg::DATA_W-1:0]  pwdata,
    output logic [ids_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    ids_pix_if.sink                     pix,
    ids_dgram_if.source                 dgram
);

    ids_pkg::cfg_t  cfg;
    ids_pkg::qent_t push_ent;
    ids_pkg::qent_t head_ent;
    logic           push;
    logic           q_full;
    logic           pop;
    logic           head_valid;

    ids_cfg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ids_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .pix      (pix),
        .q_full   (q_full),
        .push     (push),
        .push_ent (push_ent)
    );

    ids_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ent   (push_ent),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_ent   (head_ent)
    );

    ids_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head_ent   (head_ent),
        .pop        (pop),
        .dgram      (dgram)
    );

endmodule

>>> sv/ids_cfg_regs.sv
// apb-style configuration registers of the segmenter
// depends on ids_pkg
module ids_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ids_pkg::ADDR_W-1:0]  paddr,
    input  logic [ids_pkg::DATA_W-1:0]  pwdata,
    output logic [ids_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output ids_pkg::cfg_t               cfg
);

    ids_pkg::cfg_t cfg_reg;
    logic [2:0]    idx;
    logic          wr_en;

    assign idx    = paddr[ids_pkg::ADDR_W-1:3];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.datagram_size <= ids_pkg::RESET_DGRAM;
            cfg_reg.image_length  <= ids_pkg::RESET_ILEN;
            cfg_reg.message_ids   <= '0;
            cfg_reg.time_stamp    <= '0;
            cfg_reg.image_dims    <= '0;
            cfg_reg.image_format  <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                ids_pkg::REG_DGRAM_SIZE: cfg_reg.datagram_size <= pwdata[15:0];
                ids_pkg::REG_IMAGE_LEN:  cfg_reg.image_length  <= pwdata[31:0];
                ids_pkg::REG_MSG_IDS:    cfg_reg.message_ids   <= pwdata[31:0];
                ids_pkg::REG_TIME_STAMP: cfg_reg.time_stamp    <= pwdata[31:0];
                ids_pkg::REG_IMAGE_DIMS: cfg_reg.image_dims    <= pwdata[47:0];
                ids_pkg::REG_IMAGE_FMT:  cfg_reg.image_format  <= pwdata[39:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            ids_pkg::REG_DGRAM_SIZE: prdata = {48'd0, cfg_reg.datagram_size};
            ids_pkg::REG_IMAGE_LEN:  prdata = {32'd0, cfg_reg.image_length};
            ids_pkg::REG_MSG_IDS:    prdata = {32'd0, cfg_reg.message_ids};
            ids_pkg::REG_TIME_STAMP: prdata = {32'd0, cfg_reg.time_stamp};
            ids_pkg::REG_IMAGE_DIMS: prdata = {16'd0, cfg_reg.image_dims};
            ids_pkg::REG_IMAGE_FMT:  prdata = {24'd0, cfg_reg.image_format};
            default:                 prdata = '0;
        endcase
    end

endmodule

>>> sv/ids_front.sv
// front end: accepts image bytes, tracks datagram boundaries, classifies each word
// depends on ids_pkg and ids_pix_if
module ids_front (
    input  logic            clk,
    input  logic            rst_n,
    input  ids_pkg::cfg_t   cfg,
    ids_pix_if.sink         pix,
    input  logic            q_full,
    output logic            push,
    output ids_pkg::qent_t  push_ent
);

    logic [15:0] pos_reg;
    logic [31:0] cons_reg;
    logic [15:0] len_reg;
    logic        fin_reg;

    logic        start;
    logic [15:0] ds_eff;
    logic [15:0] plen;
    logic [31:0] ilen_eff;
    logic [31:0] rem;
    logic        new_fin;
    logic [15:0] new_len;
    logic [15:0] len_use;
    logic        fin_use;
    logic [16:0] pos_inc;
    logic        dlast;
    logic [15:0] pos_next;
    logic [31:0] cons_next;

    assign start    = (pos_reg == 16'd0);
    assign ds_eff   = (cfg.datagram_size < ids_pkg::MIN_DGRAM) ? ids_pkg::MIN_DGRAM
                                                               : cfg.datagram_size;
    assign plen     = ds_eff - ids_pkg::HDR_BYTES_16;
    assign ilen_eff = (cfg.image_length == 32'd0) ? 32'd1 : cfg.image_length;
    // length shrunk to or below what was taken: one-byte final datagram
    assign rem      = (ilen_eff > cons_reg) ? (ilen_eff - cons_reg) : 32'd1;
    assign new_fin  = (rem <= {16'd0, plen});
    assign new_len  = new_fin ? rem[15:0] : plen;
    assign len_use  = start ? new_len : len_reg;
    assign fin_use  = start ? new_fin : fin_reg;
    assign pos_inc  = {1'b0, pos_reg} + 17'd1;
    assign dlast    = (pos_inc >= {1'b0, len_use});

    assign pix.ready = !q_full;
    assign push      = pix.valid && !q_full;

    assign push_ent.pixel_byte    = pix.pixel_byte;
    assign push_ent.start         = start;
    assign push_ent.length_word   = new_fin ? rem[15:0] : ids_pkg::NONFINAL_LEN;
    assign push_ent.datagram_last = dlast;
    assign push_ent.image_last    = dlast && fin_use;

    always_comb
    begin
        pos_next  = pos_inc[15:0];
        cons_next = cons_reg + 32'd1;
        if (dlast)
        begin
            pos_next = 16'd0;
            if (fin_use)
            begin
                cons_next = 32'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            cons_reg <= '0;
            len_reg  <= '0;
            fin_reg  <= 1'b0;
        end
        else if (push)
        begin
            pos_reg  <= pos_next;
            cons_reg <= cons_next;
            if (start)
            begin
                len_reg <= new_len;
                fin_reg <= new_fin;
            end
        end
    end

endmodule

>>> sv/ids_queue.sv
// short word queue between front and back
// depends on ids_pkg
module ids_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ids_pkg::qent_t  push_ent,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output ids_pkg::qent_t  head_ent
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    ids_pkg::qent_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full       = (cnt_reg == FULL_CNT);
    assign head_valid = (cnt_reg != '0);
    assign head_ent   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_ent;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

>>> sv/ids_back.sv
// back end: expands a start word into the 21-byte header, then emits the payload byte
// depends on ids_pkg, ids_dgram_if and the assertion macro header
`include "image_datagram_segmenter_macros.svh"

module ids_back (
    input  logic            clk,
    input  logic            rst_n,
    input  ids_pkg::cfg_t   cfg,
    input  logic            head_valid,
    input  ids_pkg::qent_t  head_ent,
    output logic            pop,
    ids_dgram_if.source     dgram
);

    logic [4:0] hdr_cnt_reg;
    logic [4:0] hdr_cnt_next;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       run_last_reg;
    logic       dlast_reg;
    logic       ilast_reg;

    logic       advance;
    logic       in_hdr;
    logic [7:0] hdr_byte;

    assign advance = !out_valid_reg || dgram.ready;
    assign in_hdr  = head_ent.start && (hdr_cnt_reg != ids_pkg::HDR_BYTES);
    assign pop     = advance && head_valid && !in_hdr;

    always_comb
    begin
        case (hdr_cnt_reg)
            5'd0:    hdr_byte = cfg.message_ids[7:0];
            5'd1:    hdr_byte = cfg.message_ids[15:8];
            5'd2:    hdr_byte = cfg.message_ids[23:16];
            5'd3:    hdr_byte = cfg.message_ids[31:24];
            5'd4:    hdr_byte = cfg.time_stamp[7:0];
            5'd5:    hdr_byte = cfg.time_stamp[15:8];
            5'd6:    hdr_byte = cfg.time_stamp[23:16];
            5'd7:    hdr_byte = cfg.time_stamp[31:24];
            5'd8:    hdr_byte = head_ent.length_word[7:0];
            5'd9:    hdr_byte = head_ent.length_word[15:8];
            5'd10:   hdr_byte = cfg.image_dims[7:0];
            5'd11:   hdr_byte = cfg.image_dims[15:8];
            5'd12:   hdr_byte = cfg.image_dims[23:16];
            5'd13:   hdr_byte = cfg.image_dims[31:24];
            5'd14:   hdr_byte = cfg.image_dims[39:32];
            5'd15:   hdr_byte = cfg.image_dims[47:40];
            5'd16:   hdr_byte = cfg.image_format[7:0];
            5'd17:   hdr_byte = cfg.image_format[15:8];
            5'd18:   hdr_byte = cfg.image_format[23:16];
            5'd19:   hdr_byte = cfg.image_format[31:24];
            5'd20:   hdr_byte = cfg.image_format[39:32];
            default: hdr_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        hdr_cnt_next = hdr_cnt_reg;
        if (advance && head_valid)
        begin
            hdr_cnt_next = in_hdr ? hdr_cnt_reg + 5'd1 : 5'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            hdr_cnt_reg <= hdr_cnt_next;
            if (advance)
            begin
                out_valid_reg <= head_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && head_valid)
        begin
            if (in_hdr)
            begin
                out_byte_reg <= hdr_byte;
                run_last_reg <= 1'b0;
                dlast_reg    <= 1'b0;
                ilast_reg    <= 1'b0;
            end
            else
            begin
                out_byte_reg <= head_ent.pixel_byte;
                run_last_reg <= 1'b1;
                dlast_reg    <= head_ent.datagram_last;
                ilast_reg    <= head_ent.image_last;
            end
        end
    end

    assign dgram.valid         = out_valid_reg;
    assign dgram.out_byte      = out_byte_reg;
    assign dgram.run_last      = run_last_reg;
    assign dgram.datagram_last = dlast_reg;
    assign dgram.image_last    = ilast_reg;

    `IDS_ASSERT(a_hdr_cnt_range, hdr_cnt_reg <= ids_pkg::HDR_BYTES, "header counter overran")
    `IDS_ASSERT(a_ilast_ends_dgram, !(out_valid_reg && ilast_reg) || dlast_reg, "image end without datagram end")
    `IDS_ASSERT(a_hdr_no_flags, !(out_valid_reg && !run_last_reg) || !dlast_reg, "header byte flagged as datagram end")
    `IDS_ASSERT_NEXT(a_hdr_then_more, out_valid_reg && !run_last_reg && dgram.ready, out_valid_reg, "header cut short")

endmodule

>>> tb/sv/image_datagram_segmenter_test.sv
// self-checking testbench for the image datagram segmenter: directed table, then random images
// needs ids_pkg, ids_pix_if, ids_dgram_if and image_datagram_segmenter
module image_datagram_segmenter_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 1;
    localparam int NUM_DIRECTED = 53;
    localparam int RANDOM_ITEMS = 230;
    localparam int SETTLE       = 4;
    localparam int DRAIN        = 30;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       datagram_last;
        logic       image_last;
    } dgram_word_t;

    typedef enum logic {ROW_CFG, ROW_PIX} row_kind_e;

    // a pixel row with checked set carries its own expected header length and flags
    typedef struct packed {
        row_kind_e   kind;
        logic [2:0]  reg_idx;
        logic [63:0] value;
        logic [7:0]  pix;
        logic        checked;
        logic        has_header;
        logic [15:0] length_word;
        logic        dgram_end;
        logic        image_end;
    } stim_row_t;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [ids_pkg::ADDR_W-1:0]   paddr;
    logic [ids_pkg::DATA_W-1:0]   pwdata;
    logic [ids_pkg::DATA_W-1:0]   prdata;
    logic                         pready;

    ids_pix_if   pix_ch ();
    ids_dgram_if dgram_ch ();

    // shadow copy of the registers and the segmenting state
    ids_pkg::cfg_t shadow_cfg;
    logic [15:0]   pay_pos;
    logic [15:0]   cur_len;
    logic [31:0]   img_bytes;
    logic          dgram_final;

    dgram_word_t expected_words [$];
    int          fail_count = 0;
    bit          no_gaps = 1'b0;

    image_datagram_segmenter u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pix     (pix_ch),
        .dgram   (dgram_ch)
    );

    always #CLK_HALF clk = ~clk;

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 30);
    endfunction

    function automatic logic [7:0] header_byte(int unsigned k, logic [15:0] lw);
        logic [167:0] hdr;
        hdr = {shadow_cfg.image_format, shadow_cfg.image_dims, lw,
               shadow_cfg.time_stamp, shadow_cfg.message_ids};
        return hdr[8*k +: 8];
    endfunction

    function automatic stim_row_t cfg_row(logic [2:0] idx, logic [63:0] val);
        stim_row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.reg_idx = idx;
        r.value = val;
        return r;
    endfunction

    function automatic stim_row_t pix_row(logic [7:0] b);
        stim_row_t r;
        r = '0;
        r.kind = ROW_PIX;
        r.pix = b;
        return r;
    endfunction

    function automatic stim_row_t chk_row(logic [7:0] b, logic hdr, logic [15:0] lw,
                                          logic dl, logic il);
        stim_row_t r;
        r = pix_row(b);
        r.checked = 1'b1;
        r.has_header = hdr;
        r.length_word = lw;
        r.dgram_end = dl;
        r.image_end = il;
        return r;
    endfunction

    // works out the words one accepted pixel causes and queues them
    task automatic segment_pixel(input stim_row_t r);
        logic [15:0] ds;
        logic [15:0] plen;
        logic [15:0] lw;
        logic [32:0] ilen;
        logic [32:0] rem;
        logic        hdr;
        logic        dl;
        logic        il;
        hdr = (pay_pos == 16'd0);
        lw = '0;
        if (hdr)
        begin
            ds = (shadow_cfg.datagram_size < ids_pkg::MIN_DGRAM) ? ids_pkg::MIN_DGRAM
                                                                 : shadow_cfg.datagram_size;
            plen = ds - ids_pkg::HDR_BYTES_16;
            ilen = (shadow_cfg.image_length == 32'd0) ? 33'd1
                                                      : {1'b0, shadow_cfg.image_length};
            rem = (ilen > {1'b0, img_bytes}) ? ilen - {1'b0, img_bytes} : 33'd1;
            if (rem <= {17'd0, plen})
            begin
                dgram_final = 1'b1;
                cur_len = rem[15:0];
                lw = rem[15:0];
            end
            else
            begin
                dgram_final = 1'b0;
                cur_len = plen;
                lw = ids_pkg::NONFINAL_LEN;
            end
        end
        pay_pos++;
        img_bytes++;
        dl = (pay_pos >= cur_len);
        il = dl && dgram_final;
        if (dl)
        begin
            pay_pos = '0;
            if (dgram_final)
                img_bytes = '0;
        end
        if (r.checked)
        begin
            hdr = r.has_header;
            lw = r.length_word;
            dl = r.dgram_end;
            il = r.image_end;
        end
        if (hdr)
            for (int k = 0; k < int'(ids_pkg::HDR_BYTES); k++)
                expected_words.push_back({header_byte(k, lw), 3'b000});
        expected_words.push_back({r.pix, 1'b1, dl, il});
    endtask

    task automatic wait_idle();
        pix_ch.valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        wait_idle();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            ids_pkg::REG_DGRAM_SIZE: shadow_cfg.datagram_size = val[15:0];
            ids_pkg::REG_IMAGE_LEN:  shadow_cfg.image_length = val[31:0];
            ids_pkg::REG_MSG_IDS:    shadow_cfg.message_ids = val[31:0];
            ids_pkg::REG_TIME_STAMP: shadow_cfg.time_stamp = val[31:0];
            ids_pkg::REG_IMAGE_DIMS: shadow_cfg.image_dims = val[47:0];
            ids_pkg::REG_IMAGE_FMT:  shadow_cfg.image_format = val[39:0];
            default: ;
        endcase
    endtask

    task automatic send_pixel(input stim_row_t r);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.pixel_byte <= r.pix;
        @(posedge clk);
        while (!pix_ch.ready)
            @(posedge clk);
        segment_pixel(r);
    endtask

    initial
    begin : stimulus
        stim_row_t   directed_rows [NUM_DIRECTED];
        int unsigned random_items;
        int unsigned count;
        int unsigned span;
        logic [15:0] ds;
        logic [31:0] ilen;
        bit          first;

        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pix_ch.valid = 1'b0;
        pix_ch.pixel_byte = '0;

        shadow_cfg = '0;
        shadow_cfg.datagram_size = ids_pkg::RESET_DGRAM;
        shadow_cfg.image_length = ids_pkg::RESET_ILEN;
        pay_pos = '0;
        cur_len = '0;
        img_bytes = '0;
        dgram_final = 1'b0;

        directed_rows = '{
            // one-byte images straight out of reset
            chk_row(8'h00, 1'b1, 16'd1, 1'b1, 1'b1),
            chk_row(8'hff, 1'b1, 16'd1, 1'b1, 1'b1),
            // smallest datagram, all header fields at ones
            cfg_row(ids_pkg::REG_DGRAM_SIZE, ids_pkg::MIN_DGRAM),
            cfg_row(ids_pkg::REG_IMAGE_LEN, 64'd3),
            cfg_row(ids_pkg::REG_MSG_IDS, 64'hffff_ffff),
            cfg_row(ids_pkg::REG_TIME_STAMP, 64'hffff_ffff),
            cfg_row(ids_pkg::REG_IMAGE_DIMS, 64'hffff_ffff_ffff),
            cfg_row(ids_pkg::REG_IMAGE_FMT, 64'hff_ffff_ffff),
            chk_row(8'ha5, 1'b1, ids_pkg::NONFINAL_LEN, 1'b1, 1'b0),
            chk_row(8'h5a, 1'b1, ids_pkg::NONFINAL_LEN, 1'b1, 1'b0),
            chk_row(8'h3c, 1'b1, 16'd1, 1'b1, 1'b1),
            // size below the minimum and zero image length
            cfg_row(ids_pkg::REG_DGRAM_SIZE, 64'd10),
            cfg_row(ids_pkg::REG_IMAGE_LEN, 64'd0),
            cfg_row(ids_pkg::REG_MSG_IDS, 64'h1234_5678),
            cfg_row(ids_pkg::REG_TIME_STAMP, 64'h89ab_cdef),
            cfg_row(ids_pkg::REG_IMAGE_DIMS, 64'd0),
            cfg_row(ids_pkg::REG_IMAGE_FMT, 64'd0),
            chk_row(8'h81, 1'b1, 16'd1, 1'b1, 1'b1),
            chk_row(8'h7e, 1'b1, 16'd1, 1'b1, 1'b1),
            // image exactly one payload long
            cfg_row(ids_pkg::REG_DGRAM_SIZE, 64'd25),
            cfg_row(ids_pkg::REG_IMAGE_LEN, 64'd4),
            chk_row(8'h01, 1'b1, 16'd4, 1'b0, 1'b0),
            pix_row(8'h02),
            pix_row(8'h03),
            chk_row(8'h04, 1'b0, 16'd0, 1'b1, 1'b1),
            // image length cut below what was already taken
            cfg_row(ids_pkg::REG_DGRAM_SIZE, 64'd24),
            cfg_row(ids_pkg::REG_IMAGE_LEN, 64'd10),
            pix_row(8'h10),
            pix_row(8'h11),
            pix_row(8'h12),
            cfg_row(ids_pkg::REG_IMAGE_LEN, 64'd2),
            chk_row(8'h13, 1'b1, 16'd1, 1'b1, 1'b1),
            // registers rewritten inside a datagram
            cfg_row(ids_pkg::REG_DGRAM_SIZE, 64'd26),
            cfg_row(ids_pkg::REG_IMAGE_LEN, 64'd7),
            chk_row(8'h20, 1'b1, ids_pkg::NONFINAL_LEN, 1'b0, 1'b0),
            pix_row(8'h21),
            cfg_row(ids_pkg::REG_IMAGE_LEN, 64'd3),
            cfg_row(ids_pkg::REG_DGRAM_SIZE, ids_pkg::MIN_DGRAM),
            cfg_row(ids_pkg::REG_MSG_IDS, 64'h0bad_f00d),
            cfg_row(ids_pkg::REG_IMAGE_DIMS, 64'h1234_5678_9abc),
            pix_row(8'h22),
            pix_row(8'h23),
            chk_row(8'h24, 1'b0, 16'd0, 1'b1, 1'b0),
            chk_row(8'h25, 1'b1, 16'd1, 1'b1, 1'b1),
            // largest datagram
            cfg_row(ids_pkg::REG_DGRAM_SIZE, 64'hffff),
            cfg_row(ids_pkg::REG_IMAGE_LEN, 64'd2),
            chk_row(8'hc3, 1'b1, 16'd2, 1'b0, 1'b0),
            pix_row(8'h3c),
            // largest image length
            cfg_row(ids_pkg::REG_DGRAM_SIZE, ids_pkg::MIN_DGRAM),
            cfg_row(ids_pkg::REG_IMAGE_LEN, 64'hffff_ffff),
            chk_row(8'h66, 1'b1, ids_pkg::NONFINAL_LEN, 1'b1, 1'b0),
            cfg_row(ids_pkg::REG_IMAGE_LEN, 64'd1),
            chk_row(8'h99, 1'b1, 16'd1, 1'b1, 1'b1)
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
                write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
            else
                send_pixel(directed_rows[i]);
        end

        random_items = 0;
        first = 1'b1;
        while (random_items < RANDOM_ITEMS)
        begin
            no_gaps = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0: ds = 16'($urandom_range(0, 21));
                1: ds = 16'hffff;
                default: ds = 16'($urandom_range(22, 45));
            endcase
            ilen = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom_range(1, 70);
            write_reg(ids_pkg::REG_DGRAM_SIZE, {48'd0, ds});
            write_reg(ids_pkg::REG_IMAGE_LEN, {32'd0, ilen});
            if (first || $urandom_range(0, 1) == 1)
                write_reg(ids_pkg::REG_MSG_IDS, {32'd0, $urandom()});
            if (first || $urandom_range(0, 1) == 1)
                write_reg(ids_pkg::REG_TIME_STAMP, {32'd0, $urandom()});
            if (first || $urandom_range(0, 1) == 1)
                write_reg(ids_pkg::REG_IMAGE_DIMS,
                          {$urandom(), $urandom()} & 64'hffff_ffff_ffff);
            if (first || $urandom_range(0, 1) == 1)
                write_reg(ids_pkg::REG_IMAGE_FMT,
                          {$urandom(), $urandom()} & 64'hff_ffff_ffff);
            first = 1'b0;
            // mostly whole images, now and then a cut-off one
            span = (ilen == 32'd0) ? 1 : ilen;
            count = ($urandom_range(0, 4) != 0) ? span : $urandom_range(1, span);
            for (int unsigned k = 0; k < count; k++)
            begin
                if ($urandom_range(0, 39) == 0)
                    wait_idle();
                send_pixel(pix_row(8'($urandom_range(0, 255))));
            end
            random_items += count;
        end

        wait_idle();
        repeat (DRAIN) @(posedge clk);
        if (fail_count == 0 && expected_words.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin : receiver
        dgram_word_t got;
        dgram_word_t want;
        int unsigned stall;
        stall = 0;
        dgram_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (dgram_ch.valid && dgram_ch.ready)
                begin
                    got = {dgram_ch.out_byte, dgram_ch.run_last,
                           dgram_ch.datagram_last, dgram_ch.image_last};
                    if (expected_words.size() == 0)
                    begin
                        $display("%0t: expected no word, got %02h run %b dgram %b image %b",
                                 $time, got.out_byte, got.run_last,
                                 got.datagram_last, got.image_last);
                        fail_count++;
                    end
                    else
                    begin
                        want = expected_words.pop_front();
                        if (got.out_byte !== want.out_byte || got.run_last !== want.run_last ||
                            got.datagram_last !== want.datagram_last ||
                            got.image_last !== want.image_last)
                        begin
                            $display("%0t: expected %02h %b%b%b, got %02h %b%b%b",
                                     $time, want.out_byte, want.run_last,
                                     want.datagram_last, want.image_last,
                                     got.out_byte, got.run_last,
                                     got.datagram_last, got.image_last);
                            fail_count++;
                        end
                    end
                end
                if (stall != 0)
                begin
                    dgram_ch.ready <= 1'b0;
                    stall--;
                end
                else
                begin
                    dgram_ch.ready <= 1'b1;
                    stall = pick_gap();
                end
            end
        end
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
